[hdl/advection_stencil_update_macros.svh]
// Assertion macros for the advection stencil update checker.
// Needs clk and rst_n visible where used.
`ifndef ADVECTION_STENCIL_UPDATE_MACROS_SVH
`define ADVECTION_STENCIL_UPDATE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil check failed");

// Next-cycle implication, disabled in reset.
`define ASU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil check failed");

`endif

[hdl/asu_pkg.sv]
// Package for the advection stencil update: payload types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package asu_pkg;

    localparam int CfgAddrW = 2;
    localparam int CfgDataW = 18;

    localparam logic [CfgAddrW-1:0] REG_COURANT  = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_PERIODIC = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_ZERO_RE  = 2'd2;

    localparam logic [17:0] COURANT_RESET = 18'd52429;

    localparam logic [2:0] MODE_FWD     = 3'd0;
    localparam logic [2:0] MODE_BWD     = 3'd1;
    localparam logic [2:0] MODE_CENTRAL = 3'd2;
    localparam logic [2:0] MODE_LXF     = 3'd3;
    localparam logic [2:0] MODE_LEAP    = 3'd4;
    localparam logic [2:0] MODE_EQUIL   = 3'd5;
    localparam logic [2:0] MODE_LXW     = 3'd6;

    localparam logic signed [33:0] Q_ONE      = 34'sd65536;
    localparam logic signed [31:0] BLOW_LIMIT = 32'sd327680;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] left_value;
        logic signed [31:0] center_value;
        logic signed [31:0] right_value;
        logic signed [31:0] older_center;
        logic signed [19:0] speed;
        logic signed [31:0] force_left;
        logic signed [31:0] force_center;
        logic signed [31:0] force_right;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_value;
        logic               blowup_flag;
    } out_item_t;

endpackage
`default_nettype wire

[hdl/advection_stencil_update.sv]
// Throughput: one item per cycle sustained while the output is not stalled.
// Stages: speed*ratio, Courant round, c squared, weights, three multiplies, sum/round/sat.
// A stalled output holds the pipe; bubbles collapse, so ready drops only when all are full.
// Reset (async, active low) empties the pipe and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module advection_stencil_update (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [asu_pkg::CfgAddrW-1:0]    cfg_addr,
    input  wire logic [asu_pkg::CfgDataW-1:0]    cfg_data,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire asu_pkg::in_item_t               item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output asu_pkg::out_item_t                   result
);
    import asu_pkg::*;

    localparam int NStages = 6;

    // configuration registers
    logic [17:0] courant_reg;
    logic        periodic_reg;
    logic        zero_re_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            courant_reg  <= COURANT_RESET;
            periodic_reg <= 1'b1;
            zero_re_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_COURANT:  courant_reg  <= cfg_data;
                REG_PERIODIC: periodic_reg <= cfg_data[0];
                REG_ZERO_RE:  zero_re_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // valid chain; a stage loads when empty or when the one after it moves
    logic [NStages:1] v_reg;
    logic [NStages:1] ld;
    logic [NStages:1] take;

    always_comb
    begin
        ld[NStages] = !v_reg[NStages] || result_ready;
        for (int k = NStages - 1; k >= 1; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        take[1] = ld[1] && item_valid;
        for (int k = 2; k <= NStages; k++)
        begin
            take[k] = ld[k] && v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[1])
            begin
                v_reg[1] <= item_valid;
            end
            for (int k = 2; k <= NStages; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign item_ready   = ld[1];
    assign result_valid = v_reg[NStages];

    // ---- stage 1: edge rules, speed * ratio ----
    logic               open_edge;
    logic               s1_zero_next;
    logic signed [31:0] s1_r_next;
    logic signed [38:0] s1_p_next;

    always_comb
    begin
        open_edge    = !periodic_reg;
        s1_zero_next = open_edge && item.is_last && zero_re_reg;
        s1_r_next    = (open_edge && item.is_last && item.mode != MODE_BWD)
                       ? item.center_value : item.right_value;
        s1_p_next    = 39'(item.speed) * $signed({1'b0, courant_reg});
    end

    logic [2:0]         s1_mode_reg;
    logic               s1_last_reg, s1_zero_reg;
    logic signed [31:0] s1_l_reg, s1_c_reg, s1_r_reg, s1_o_reg;
    logic signed [31:0] s1_fl_reg, s1_fc_reg, s1_fr_reg;
    logic signed [38:0] s1_p_reg;

    always_ff @(posedge clk)
    begin
        if (take[1])
        begin
            s1_mode_reg <= item.mode;
            s1_last_reg <= item.is_last;
            s1_zero_reg <= s1_zero_next;
            s1_l_reg    <= item.left_value;
            s1_c_reg    <= item.center_value;
            s1_r_reg    <= s1_r_next;
            s1_o_reg    <= item.older_center;
            s1_fl_reg   <= item.force_left;
            s1_fc_reg   <= item.force_center;
            s1_fr_reg   <= item.force_right;
            s1_p_reg    <= s1_p_next;
        end
    end

    // ---- stage 2: round Courant number, forced sums ----
    logic signed [39:0] c_wide;

    assign c_wide = (40'(s1_p_reg) + 40'sd32768) >>> 16;

    logic [2:0]         s2_mode_reg;
    logic               s2_last_reg, s2_zero_reg;
    logic signed [31:0] s2_l_reg, s2_c_reg, s2_r_reg, s2_o_reg;
    logic signed [32:0] s2_le_reg, s2_ce_reg, s2_re_reg;
    logic signed [23:0] s2_cn_reg;

    always_ff @(posedge clk)
    begin
        if (take[2])
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_last_reg <= s1_last_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_l_reg    <= s1_l_reg;
            s2_c_reg    <= s1_c_reg;
            s2_r_reg    <= s1_r_reg;
            s2_o_reg    <= s1_o_reg;
            s2_le_reg   <= 33'(s1_l_reg) + 33'(s1_fl_reg);
            s2_ce_reg   <= 33'(s1_c_reg) + 33'(s1_fc_reg);
            s2_re_reg   <= 33'(s1_r_reg) + 33'(s1_fr_reg);
            s2_cn_reg   <= c_wide[23:0];
        end
    end

    // ---- stage 3: c squared ----
    logic [2:0]         s3_mode_reg;
    logic               s3_last_reg, s3_zero_reg;
    logic signed [31:0] s3_l_reg, s3_c_reg, s3_r_reg, s3_o_reg;
    logic signed [32:0] s3_le_reg, s3_ce_reg, s3_re_reg;
    logic signed [23:0] s3_cn_reg;
    logic signed [47:0] s3_csq_reg;

    always_ff @(posedge clk)
    begin
        if (take[3])
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_last_reg <= s2_last_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_l_reg    <= s2_l_reg;
            s3_c_reg    <= s2_c_reg;
            s3_r_reg    <= s2_r_reg;
            s3_o_reg    <= s2_o_reg;
            s3_le_reg   <= s2_le_reg;
            s3_ce_reg   <= s2_ce_reg;
            s3_re_reg   <= s2_re_reg;
            s3_cn_reg   <= s2_cn_reg;
            s3_csq_reg  <= 48'(s2_cn_reg) * 48'(s2_cn_reg);
        end
    end

    // ---- stage 4: round c^2, pick operands and weights ----
    logic signed [47:0] c2_wide;
    logic signed [32:0] xl, xc, xr;
    logic signed [31:0] kl, kc, kr;

    assign c2_wide = (s3_csq_reg + 48'sd32768) >>> 16;

    asu_coef u_coef (
        .mode    (s3_mode_reg),
        .is_last (s3_last_reg),
        .c       (s3_cn_reg),
        .c2      (c2_wide[31:0]),
        .lv      (s3_l_reg),
        .cv      (s3_c_reg),
        .rv      (s3_r_reg),
        .ov      (s3_o_reg),
        .le      (s3_le_reg),
        .ce      (s3_ce_reg),
        .re      (s3_re_reg),
        .xl      (xl),
        .xc      (xc),
        .xr      (xr),
        .kl      (kl),
        .kc      (kc),
        .kr      (kr)
    );

    logic               s4_zero_reg;
    logic signed [32:0] s4_xl_reg, s4_xc_reg, s4_xr_reg;
    logic signed [31:0] s4_kl_reg, s4_kc_reg, s4_kr_reg;

    always_ff @(posedge clk)
    begin
        if (take[4])
        begin
            s4_zero_reg <= s3_zero_reg;
            s4_xl_reg   <= xl;
            s4_xc_reg   <= xc;
            s4_xr_reg   <= xr;
            s4_kl_reg   <= kl;
            s4_kc_reg   <= kc;
            s4_kr_reg   <= kr;
        end
    end

    // ---- stage 5: three products, Q.33 ----
    logic               s5_zero_reg;
    logic signed [64:0] s5_pl_reg, s5_pc_reg, s5_pr_reg;

    always_ff @(posedge clk)
    begin
        if (take[5])
        begin
            s5_zero_reg <= s4_zero_reg;
            s5_pl_reg   <= 65'(s4_xl_reg) * 65'(s4_kl_reg);
            s5_pc_reg   <= 65'(s4_xc_reg) * 65'(s4_kc_reg);
            s5_pr_reg   <= 65'(s4_xr_reg) * 65'(s4_kr_reg);
        end
    end

    // ---- stage 6: sum, round to Q16.16, saturate, zero edge, flag ----
    logic signed [66:0] acc;
    logic signed [66:0] rnd;
    logic signed [31:0] sat;
    logic               blow;

    always_comb
    begin
        acc = 67'(s5_pl_reg) + 67'(s5_pc_reg) + 67'(s5_pr_reg) + 67'sd65536;
        rnd = acc >>> 17;
        if (rnd > 67'sd2147483647)
        begin
            sat = 32'sh7FFFFFFF;
        end
        else if (rnd < -67'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = rnd[31:0];
        end
        if (s5_zero_reg)
        begin
            sat = '0;
        end
        blow = (sat > BLOW_LIMIT) || (sat < -BLOW_LIMIT);
    end

    out_item_t out_reg;

    always_ff @(posedge clk)
    begin
        if (take[6])
        begin
            out_reg.new_value   <= sat;
            out_reg.blowup_flag <= blow;
        end
    end

    assign result = out_reg;

endmodule
`default_nettype wire

[hdl/asu_coef.sv]
// Per-mode operand select and Q.17 weight builder for the stencil.
// Depends on asu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asu_coef (
    input  wire logic [2:0]         mode,
    input  wire logic               is_last,
    input  wire logic signed [23:0] c,
    input  wire logic signed [31:0] c2,
    input  wire logic signed [31:0] lv,
    input  wire logic signed [31:0] cv,
    input  wire logic signed [31:0] rv,
    input  wire logic signed [31:0] ov,
    input  wire logic signed [32:0] le,
    input  wire logic signed [32:0] ce,
    input  wire logic signed [32:0] re,
    output logic signed [32:0]      xl,
    output logic signed [32:0]      xc,
    output logic signed [32:0]      xr,
    output logic signed [31:0]      kl,
    output logic signed [31:0]      kc,
    output logic signed [31:0]      kr
);
    import asu_pkg::*;

    logic signed [33:0] cs;
    logic signed [33:0] c2s;
    logic signed [33:0] wl;
    logic signed [33:0] wc;
    logic signed [33:0] wr;

    always_comb
    begin
        cs  = 34'(c);
        c2s = 34'(c2);
        xl  = 33'(lv);
        xc  = 33'(cv);
        xr  = 33'(rv);
        wl  = '0;
        wc  = '0;
        wr  = '0;
        unique case (mode)
            MODE_FWD:
            begin
                wc = (Q_ONE + cs) <<< 1;
                wr = -(cs <<< 1);
            end
            MODE_BWD:
            begin
                wl = cs <<< 1;
                wc = (Q_ONE - cs) <<< 1;
            end
            MODE_CENTRAL:
            begin
                wl = cs;
                wc = Q_ONE <<< 1;
                wr = -cs;
            end
            MODE_LXF:
            begin
                wl = Q_ONE + cs;
                wr = Q_ONE - cs;
            end
            MODE_LEAP:
            begin
                xc = 33'(ov);
                wl = cs <<< 1;
                wc = Q_ONE <<< 1;
                wr = -(cs <<< 1);
            end
            MODE_EQUIL:
            begin
                xl = le;
                xc = ce;
                xr = re;
                if (is_last)
                begin
                    wl = (cs <<< 1) + cs - c2s;
                    wc = (Q_ONE - cs) <<< 1;
                end
                else
                begin
                    wl = cs + c2s;
                    wc = (Q_ONE - c2s) <<< 1;
                    wr = c2s - cs;
                end
            end
            MODE_LXW:
            begin
                wl = cs + c2s;
                wc = (Q_ONE - c2s) <<< 1;
                wr = c2s - cs;
            end
            default:
            begin
                wl = '0;
            end
        endcase
        kl = wl[31:0];
        kc = wc[31:0];
        kr = wr[31:0];
    end

endmodule
`default_nettype wire

[hdl/asu_checker.sv]
// Port-level checker for advection_stencil_update, bound to the top level.
// Depends on asu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "advection_stencil_update_macros.svh"
module asu_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_ready,
    input  wire logic               result_valid,
    input  wire logic               result_ready,
    input  wire asu_pkg::out_item_t result
);
    import asu_pkg::*;

    logic flag_exp;

    assign flag_exp = (result.new_value > BLOW_LIMIT) || (result.new_value < -BLOW_LIMIT);

    // a waiting result keeps its value
    `ASU_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(result))
    // input transfer pending stays offered
    `ASU_ASSERT_NEXT(a_in_hold, item_valid && !item_ready, item_valid)
    // back-pressure only when the output is stuck
    `ASU_ASSERT_NOW(a_ready, !item_ready, result_valid && !result_ready)
    // flag matches the magnitude of the value
    `ASU_ASSERT_NOW(a_flag, result_valid, result.blowup_flag == flag_exp)

endmodule

bind advection_stencil_update asu_checker u_asu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
`default_nettype wire

[test/advection_stencil_update_test.sv]
// Testbench for advection_stencil_update: directed table, then random grid points.
// Depends on asu_pkg; a built-in stencil predictor checks every result transfer.
`timescale 1ns / 1ps
`default_nettype none
module advection_stencil_update_test;
    import asu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DRAIN     = 12;

    // idle profiles, percent of cycles
    typedef enum int { PH_NONE, PH_SEND, PH_RECV, PH_BOTH } idle_phase_e;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [CfgDataW-1:0] cfg_data;
    logic                item_valid;
    logic                item_ready;
    in_item_t            item;
    logic                result_valid;
    logic                result_ready;
    out_item_t           result;

    advection_stencil_update dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Local copy of the register file
    logic [17:0] ratio_q;
    logic        periodic_q;
    logic        zero_edge_q;

    out_item_t   pending_results[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          idle_cycles;
    bit          timed_out;

    function automatic longint floor_q(input longint x, input longint d);
        longint q;
        q = x / d;
        if (x % d < 0)
            q -= 1;
        return q;
    endfunction

    // Next time-level value for one grid point under the current registers
    function automatic out_item_t stencil_update(input in_item_t p);
        out_item_t o;
        longint lv, cv, rv, ov, a, c, c2, acc, res, le, ce, re;
        bit     open_edge;
        open_edge = !periodic_q;
        o = '0;
        lv = p.left_value;
        cv = p.center_value;
        rv = p.right_value;
        ov = p.older_center;
        a  = p.speed;
        acc = 0;
        if (open_edge && p.is_last && zero_edge_q)
            return o;
        if (open_edge && p.is_last && p.mode != MODE_BWD)
            rv = cv;
        c  = floor_q(a * longint'(ratio_q) + 32768, 65536);
        c2 = floor_q(c * c + 32768, 65536);
        // weights are Q.17, acc Q.33
        case (p.mode)
            MODE_FWD:     acc = cv * (2 * (65536 + c)) + rv * (-2 * c);
            MODE_BWD:     acc = lv * (2 * c) + cv * (2 * (65536 - c));
            MODE_CENTRAL: acc = lv * c + cv * 131072 - rv * c;
            MODE_LXF:     acc = lv * (65536 + c) + rv * (65536 - c);
            MODE_LEAP:    acc = ov * 131072 + lv * (2 * c) - rv * (2 * c);
            MODE_EQUIL:
            begin
                le = lv + longint'(p.force_left);
                ce = cv + longint'(p.force_center);
                re = rv + longint'(p.force_right);
                // last cell: right term extrapolated from left and center
                if (p.is_last)
                    acc = le * (3 * c - c2) + ce * (2 * (65536 - c));
                else
                    acc = le * (c + c2) + ce * (2 * (65536 - c2)) + re * (c2 - c);
            end
            MODE_LXW:     acc = cv * (2 * (65536 - c2)) + lv * (c + c2) + rv * (c2 - c);
            default:      acc = 0;
        endcase
        res = floor_q(acc + 65536, 131072);
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        o.new_value   = res[31:0];
        o.blowup_flag = (res > 327680 || res < -327680);
        return o;
    endfunction

    // Directed rows; has_known marks a hand-computed result
    typedef struct {
        in_item_t  pt;
        bit        has_known;
        out_item_t known;
    } stim_row_t;

    stim_row_t directed_rows[$];

    function automatic in_item_t make_point(input logic [2:0] md, input int l, input int cc,
                                            input int r, input logic signed [19:0] sp,
                                            input bit last);
        in_item_t p;
        p = '0;
        p.mode = md;
        p.left_value = l;
        p.center_value = cc;
        p.right_value = r;
        p.older_center = cc;
        p.speed = sp;
        p.is_last = last;
        return p;
    endfunction

    function automatic in_item_t random_point();
        in_item_t p;
        int       kind;
        p.mode = $urandom_range(0, 7);
        kind = $urandom_range(0, 3);
        // mostly values near the blowup threshold, sometimes full range
        if (kind == 0)
        begin
            p.left_value   = $urandom;
            p.center_value = $urandom;
            p.right_value  = $urandom;
            p.older_center = $urandom;
            p.force_left   = $urandom;
            p.force_center = $urandom;
            p.force_right  = $urandom;
        end
        else
        begin
            p.left_value   = int'($urandom_range(0, 800000)) - 400000;
            p.center_value = int'($urandom_range(0, 800000)) - 400000;
            p.right_value  = int'($urandom_range(0, 800000)) - 400000;
            p.older_center = int'($urandom_range(0, 800000)) - 400000;
            p.force_left   = int'($urandom_range(0, 20000)) - 10000;
            p.force_center = int'($urandom_range(0, 20000)) - 10000;
            p.force_right  = int'($urandom_range(0, 20000)) - 10000;
        end
        p.speed = (kind == 3) ? 20'($urandom) : 20'(int'($urandom_range(0, 524288)) - 262144);
        p.is_last = ($urandom_range(0, 3) == 0);
        return p;
    endfunction

    // Offer one point and wait for its transfer; valid stays up for a back-to-back follower
    task automatic send_point(input in_item_t p);
        if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
                @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= p;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_results.push_back(stencil_update(p));
    endtask

    // Caller drops cfg_we after the last write of a group
    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [17:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_COURANT:  ratio_q     = val;
            REG_PERIODIC: periodic_q  = val[0];
            default:      zero_edge_q = val[0];
        endcase
    endtask

    // Drain outstanding results before touching registers
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic set_idle(input idle_phase_e ph);
        send_idle_pct  = (ph == PH_SEND) ? 58 : (ph == PH_BOTH) ? 15 : 0;
        recv_stall_pct = (ph == PH_RECV) ? 58 : (ph == PH_BOTH) ? 15 : 0;
    endtask

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            result_ready    <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            result_ready <= !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: new_value %0d", result.new_value);
                error_count++;
            end
            else
            begin
                out_item_t exp_r;
                exp_r = pending_results.pop_front();
                if (result.new_value !== exp_r.new_value)
                begin
                    $error("new_value: expected %0d, actual %0d", exp_r.new_value,
                           result.new_value);
                    error_count++;
                end
                if (result.blowup_flag !== exp_r.blowup_flag)
                begin
                    $error("blowup_flag: expected %0b, actual %0b", exp_r.blowup_flag,
                           result.blowup_flag);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Typed-in result check for directed rows with a known answer
    task automatic check_known(input out_item_t known, input in_item_t p);
        out_item_t pred;
        pred = stencil_update(p);
        if (pred !== known)
        begin
            $error("directed row: expected %0d/%0b, predictor %0d/%0b", known.new_value,
                   known.blowup_flag, pred.new_value, pred.blowup_flag);
            error_count++;
        end
    endtask

    initial
    begin
        stim_row_t   row;
        in_item_t    p;
        logic [17:0] ratios[4];
        int          n;
        error_count = 0;
        timed_out = 1'b0;
        idle_cycles = 0;
        hold_off_cycles = 0;
        set_idle(PH_NONE);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        item_valid = 1'b0;
        item = '0;
        ratio_q = COURANT_RESET;
        periodic_q = 1'b1;
        zero_edge_q = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: zero speed gives the center value, extremes keep it and raise the flag
        row.has_known = 1'b1;
        row.known = '{new_value: 32'sd65536, blowup_flag: 1'b0};
        for (int m = 0; m <= 6; m++)
        begin
            row.pt = make_point(m[2:0], 65536, 65536, 65536, 20'sd0, 1'b0);
            directed_rows.push_back(row);
        end
        row.pt = make_point(MODE_CENTRAL, 0, 32'h7fffffff, 0, 20'sd0, 1'b0);
        row.known = '{new_value: 32'h7fffffff, blowup_flag: 1'b1};
        directed_rows.push_back(row);
        row.pt = make_point(MODE_CENTRAL, 0, 32'h80000000, 0, 20'sd0, 1'b0);
        row.known = '{new_value: 32'h80000000, blowup_flag: 1'b1};
        directed_rows.push_back(row);
        row.pt = make_point(3'd7, 1, 2, 3, 20'sd65536, 1'b0);
        row.known = '{new_value: 0, blowup_flag: 1'b0};
        directed_rows.push_back(row);
        row.pt = make_point(MODE_CENTRAL, 0, 327681, 0, 20'sd0, 1'b0);
        row.known = '{new_value: 327681, blowup_flag: 1'b1};
        directed_rows.push_back(row);
        row.pt = make_point(MODE_CENTRAL, 0, -327680, 0, 20'sd0, 1'b0);
        row.known = '{new_value: -327680, blowup_flag: 1'b0};
        directed_rows.push_back(row);
        row.has_known = 1'b0;
        row.pt = make_point(MODE_LXW, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            20'sd262144, 1'b0);
        directed_rows.push_back(row);
        row.pt = make_point(MODE_LEAP, 32'h80000000, 0, 32'h7fffffff, -20'sd262144, 1'b1);
        row.pt.older_center = 32'h80000000;
        directed_rows.push_back(row);
        row.pt = make_point(MODE_EQUIL, 100000, 70000, -5000, 20'sd30000, 1'b1);
        row.pt.force_left = 32'hffffffff;
        row.pt.force_center = 32'h7fffffff;
        row.pt.force_right = 32'h80000000;
        directed_rows.push_back(row);
        row.pt = make_point(MODE_FWD, 3, 70000, 900000, 20'hfffff, 1'b1);
        directed_rows.push_back(row);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_known)
                check_known(directed_rows[i].known, directed_rows[i].pt);
            send_point(directed_rows[i].pt);
        end
        drain();

        // Open edge: mirrored neighbour and zeroed edge, with extreme ratios
        ratios[0] = 18'd0;
        ratios[1] = 18'd131072;
        ratios[2] = 18'h3ffff;
        ratios[3] = 18'd40000;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_COURANT, ratios[ph % 4]);
            write_reg(REG_PERIODIC, 18'(ph % 2));
            write_reg(REG_ZERO_RE, 18'((ph / 2) % 2));
            cfg_we <= 1'b0;
            set_idle(idle_phase_e'(ph % 4));
            // long receiver hold-off while points keep coming
            if (ph == 5)
                hold_off_cycles = 300;
            n = (ph == 0) ? 40 : 175;
            for (int k = 0; k < n; k++)
            begin
                p = random_point();
                // directed edge points right after a register change
                if (k < 7)
                begin
                    p.mode = k[2:0];
                    p.is_last = 1'b1;
                end
                send_point(p);
            end
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
